### hw/rtl/delta_list_sleep_queue_top_assert.svh
// ----------------------------------------------------------------------------
// delta_list_sleep_queue_top_assert.svh
// assertion macros for the sleep queue checker
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_SLEEP_QUEUE_TOP_ASSERT_SVH
`define DELTA_LIST_SLEEP_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, gated by reset
`define DLSQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlsq assertion failed");

// next-cycle implication, gated by reset
`define DLSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlsq assertion failed");

`endif

### hw/rtl/dlsq_pkg.sv
// ----------------------------------------------------------------------------
// dlsq_pkg
// shared types and constants of the delta-list sleep queue
// ----------------------------------------------------------------------------
package dlsq_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 8;
  localparam int DELTA_W     = 16;
  localparam int OUT_COUNT_W = 7;
  localparam int STATUS_W    = 3;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN,
    S_DONE
  } seq_state_t;

  // one stored list entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // request from the sequencer to the entry store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // one result word
  typedef struct packed {
    status_t                  status;
    logic [OUT_COUNT_W-1:0]   entry_count;
    logic [ID_W-1:0]          head_id;
    logic [DELTA_W-1:0]       head_delta;
  } result_t;

endpackage

### hw/rtl/dlsq_ram.sv
// ----------------------------------------------------------------------------
// dlsq_ram
// simple dual-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module dlsq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/dlsq_seq.sv
// ----------------------------------------------------------------------------
// dlsq_seq
// list walker: reads the store one entry a cycle, shifts entries up on
// insert or down on remove, writing each one back behind the read pointer
// ----------------------------------------------------------------------------
module dlsq_seq import dlsq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic               cmd_op,
  input  logic [ID_W-1:0]    cmd_id,
  input  logic [DELTA_W-1:0] cmd_ticks,
  output mem_req_t           mem_req,
  input  entry_t             mem_rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  seq_state_t         state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [DELTA_W-1:0] rest_r, rest_nxt;
  logic [DELTA_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               prc_vld_r, prc_vld_nxt;
  logic [IDX_W-1:0]   prc_idx_r, prc_idx_nxt;
  logic               hit_r, hit_nxt;
  entry_t             carry_r, carry_nxt;
  entry_t             head_r, head_nxt;
  status_t            status_r, status_nxt;

  logic               ign;
  logic               full;
  logic               walk_re;
  logic [DELTA_W:0]   sum;
  logic [DELTA_W-1:0] sum_sat;

  // command classification at accept
  assign ign  = (cmd_id == '0) || ((cmd_op == CMD_INSERT) && (cmd_ticks == '0));
  assign full = (cmd_op == CMD_INSERT) && (count_r == CNT_W'(MAX_ENTRIES));

  // read issue while entries remain
  assign walk_re = (state_r == S_WALK) && (iss_r < count_r);

  // follower delta after a remove, saturating
  assign sum     = {1'b0, mem_rdata.delta} + {1'b0, acc_r};
  assign sum_sat = sum[DELTA_W] ? {DELTA_W{1'b1}} : sum[DELTA_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (ign || full) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (!walk_re && !prc_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_nxt      = op_r;
    id_nxt      = id_r;
    rest_nxt    = rest_r;
    acc_nxt     = acc_r;
    count_nxt   = count_r;
    iss_nxt     = iss_r;
    prc_vld_nxt = 1'b0;
    prc_idx_nxt = prc_idx_r;
    hit_nxt     = hit_r;
    carry_nxt   = carry_r;
    head_nxt    = head_r;
    status_nxt  = status_r;
    mem_req     = '0;
    cmd_ready   = 1'b0;
    res_valid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_nxt    = cmd_op;
          id_nxt    = cmd_id;
          rest_nxt  = cmd_ticks;
          acc_nxt   = '0;
          iss_nxt   = '0;
          hit_nxt   = 1'b0;
          if (ign) begin
            status_nxt = ST_IGNORED;
          end else if (full) begin
            status_nxt = ST_FULL;
          end
        end
      end

      S_WALK: begin
        // issue the next read
        mem_req.re    = walk_re;
        mem_req.raddr = IDX_W'(iss_r);
        if (walk_re) begin
          iss_nxt     = CNT_W'(iss_r + 1'b1);
          prc_vld_nxt = 1'b1;
          prc_idx_nxt = IDX_W'(iss_r);
        end
        // handle the word read last cycle
        if (prc_vld_r) begin
          if (op_r == CMD_INSERT) begin
            if (!hit_r) begin
              if (mem_rdata.delta <= rest_r) begin
                rest_nxt = rest_r - mem_rdata.delta;
              end else begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = prc_idx_r;
                mem_req.wdata.id    = id_r;
                mem_req.wdata.delta = rest_r;
                carry_nxt.id        = mem_rdata.id;
                carry_nxt.delta     = mem_rdata.delta - rest_r;
                hit_nxt             = 1'b1;
              end
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = prc_idx_r;
              mem_req.wdata = carry_r;
              carry_nxt     = mem_rdata;
            end
          end else begin
            if (!hit_r) begin
              if (mem_rdata.id == id_r) begin
                hit_nxt = 1'b1;
                acc_nxt = mem_rdata.delta;
              end
            end else begin
              // shift down one place, first follower takes the removed delta
              mem_req.we          = 1'b1;
              mem_req.waddr       = IDX_W'(prc_idx_r - 1'b1);
              mem_req.wdata.id    = mem_rdata.id;
              mem_req.wdata.delta = sum_sat;
              acc_nxt             = '0;
            end
          end
        end
      end

      S_FIN: begin
        if (op_r == CMD_INSERT) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = IDX_W'(count_r);
          if (hit_r) begin
            mem_req.wdata = carry_r;
          end else begin
            mem_req.wdata.id    = id_r;
            mem_req.wdata.delta = rest_r;
          end
          count_nxt  = CNT_W'(count_r + 1'b1);
          status_nxt = ST_INSERTED;
        end else if (hit_r) begin
          count_nxt  = CNT_W'(count_r - 1'b1);
          status_nxt = ST_REMOVED;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
      end

      default: begin
        cmd_ready = 1'b0;
      end
    endcase

    // keep a copy of whatever lands at the list head
    if (mem_req.we && (mem_req.waddr == '0)) begin
      head_nxt = mem_req.wdata;
    end
  end

  // result word, empty list reads as zero head
  always_comb begin
    res.status      = status_r;
    res.entry_count = OUT_COUNT_W'(count_r);
    res.head_id     = (count_r == '0) ? '0 : head_r.id;
    res.head_delta  = (count_r == '0) ? '0 : head_r.delta;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      prc_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      prc_vld_r <= prc_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    rest_r    <= rest_nxt;
    acc_r     <= acc_nxt;
    iss_r     <= iss_nxt;
    prc_idx_r <= prc_idx_nxt;
    hit_r     <= hit_nxt;
    carry_r   <= carry_nxt;
    head_r    <= head_nxt;
    status_r  <= status_nxt;
  end

endmodule

### hw/rtl/delta_list_sleep_queue_top.sv
// ----------------------------------------------------------------------------
// delta_list_sleep_queue_top
// sleep queue kept as a delta list in a single entry store
//
//   channel | direction | words
//   in_     | input     | command, process_id, sleep_ticks
//   out_    | output    | status, entry_count, head_id, head_delta
//
// an insert or remove walks the stored entries one per store read, so a word
// takes longer from accept to result the more entries the list holds; ignored
// and full words skip the walk and go straight to the result. the walk
// occupies the single read port, so one word is in work at a time. reset is
// synchronous, active low, and empties the list at once. the output register
// lets the next word be accepted while a result waits for out_ready.
// ----------------------------------------------------------------------------
module delta_list_sleep_queue_top import dlsq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [ID_W-1:0]        in_process_id,
  input  logic [DELTA_W-1:0]     in_sleep_ticks,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [OUT_COUNT_W-1:0] out_entry_count,
  output logic [ID_W-1:0]        out_head_id,
  output logic [DELTA_W-1:0]     out_head_delta
);

  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     out_valid_r, out_valid_nxt;
  result_t  out_r;

  // entry store
  dlsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // list walker
  dlsq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_ready (in_ready),
    .cmd_op    (in_command),
    .cmd_id    (in_process_id),
    .cmd_ticks (in_sleep_ticks),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_entry_count = out_r.entry_count;
  assign out_head_id     = out_r.head_id;
  assign out_head_delta  = out_r.head_delta;

endmodule

### hw/rtl/dlsq_checker.sv
// ----------------------------------------------------------------------------
// dlsq_checker
// port-level checks on the sleep queue result words
// ----------------------------------------------------------------------------
`include "delta_list_sleep_queue_top_assert.svh"

module dlsq_checker import dlsq_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    out_status,
  input logic [OUT_COUNT_W-1:0] out_entry_count,
  input logic [ID_W-1:0]        out_head_id,
  input logic [DELTA_W-1:0]     out_head_delta
);

  // status codes stay within the defined set
  `DLSQ_ASSERT_NOW(a_status_code, out_valid, out_status <= ST_FULL)

  // count never exceeds the store
  `DLSQ_ASSERT_NOW(a_count_range, out_valid, out_entry_count <= OUT_COUNT_W'(MAX_ENTRIES))

  // an empty list shows a zero head
  `DLSQ_ASSERT_NOW(a_empty_head, out_valid && (out_entry_count == '0),
    (out_head_id == '0) && (out_head_delta == '0))

  // stored ids are never zero, so a non-empty list has a real head
  `DLSQ_ASSERT_NOW(a_head_id, out_valid && (out_entry_count != '0), out_head_id != '0)

  // a stalled result word holds its status, entry count and head id
  `DLSQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_entry_count) && $stable(out_head_id))

endmodule

bind delta_list_sleep_queue_top dlsq_checker u_dlsq_checker (.*);
